// ===== rtl/gbfe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gbfe_pkg;

    localparam int WindowBytes = 22;
    localparam int FrameBytes  = 16;

    localparam logic [7:0] SYNC_BYTE  = 8'h3F;
    localparam logic [7:0] CHECK_BYTE = 8'hAC;
    localparam logic [7:0] MSG_POS    = 8'h04;
    localparam logic [7:0] MSG_VEL    = 8'h05;
    localparam logic [7:0] MSG_TIME   = 8'h0F;
    localparam logic [7:0] MSG_DOP    = 8'h0B;

    typedef logic [7:0] byte_t;

    typedef enum logic [1:0] {
        KIND_POS  = 2'd0,
        KIND_VEL  = 2'd1,
        KIND_TIME = 2'd2,
        KIND_DOP  = 2'd3
    } frame_kind_t;

    typedef enum logic [1:0] {
        KEEP_NONE,
        KEEP_FROM_1,
        KEEP_FROM_13,
        KEEP_FROM_14
    } keep_t;

    // Request from the window logic to the output buffer.
    typedef struct packed {
        logic        load;
        logic [4:0]  count;
        frame_kind_t kind;
    } frame_load_t;

endpackage

`default_nettype wire

// ===== rtl/gps_binary_frame_extractor_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Receiver bytes are taken one word per cycle into a 22-byte window. The
// byte that fills the window is examined in the same cycle: without the
// 3F 3F sync pair the oldest byte is dropped; a position or velocity frame
// forwards window bytes 0..15, a time frame bytes 0..10 and a DOP frame
// bytes 0..11, each tagged with its kind in tuser and tlast on the final
// byte. Position and velocity frames empty the window; else the trailing
// bytes stay to start the next window. A recognized frame is copied into
// a 16-byte output buffer that drains one word per cycle while m_tready
// is high. Input is taken every cycle; it waits only when the byte would
// fill the window while the buffer still holds bytes of the previous frame.
module gps_binary_frame_extractor_core
    import gbfe_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // rx_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // out_byte
    output logic [1:0]      m_tuser,   // frame_kind
    output logic            m_tlast    // last_byte
);

    byte_t       win_reg [WindowBytes-1];
    logic [4:0]  fill_reg;
    logic [4:0]  fill_next;
    byte_t       win_full [WindowBytes];
    byte_t       frame_bytes [FrameBytes];
    logic        accept;
    logic        fills;
    keep_t       keep_sel;
    frame_load_t out_ld;
    logic        out_busy;

    assign fills    = (fill_reg == 5'(WindowBytes - 1));
    assign s_tready = !out_busy || !fills;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        for (int i = 0; i < WindowBytes - 1; i++)
        begin
            win_full[i] = win_reg[i];
        end
        win_full[WindowBytes-1] = s_tdata;
        for (int i = 0; i < FrameBytes; i++)
        begin
            frame_bytes[i] = win_full[i];
        end
    end

    always_comb
    begin
        out_ld.load  = 1'b0;
        out_ld.count = 5'd0;
        out_ld.kind  = KIND_POS;
        keep_sel     = KEEP_NONE;
        fill_next    = fill_reg;
        if (accept)
        begin
            if (!fills)
            begin
                fill_next = fill_reg + 5'd1;
            end
            else if (win_full[0] != SYNC_BYTE || win_full[1] != SYNC_BYTE)
            begin
                keep_sel  = KEEP_FROM_1;
                fill_next = 5'(WindowBytes - 1);
            end
            else
            begin
                keep_sel  = KEEP_FROM_14;
                fill_next = 5'(WindowBytes - 14);
                if (win_full[3] == CHECK_BYTE)
                begin
                    case (win_full[2])
                        MSG_POS:
                        begin
                            out_ld    = '{load: 1'b1, count: 5'd16, kind: KIND_POS};
                            keep_sel  = KEEP_NONE;
                            fill_next = 5'd0;
                        end
                        MSG_VEL:
                        begin
                            out_ld    = '{load: 1'b1, count: 5'd16, kind: KIND_VEL};
                            keep_sel  = KEEP_NONE;
                            fill_next = 5'd0;
                        end
                        MSG_TIME:
                        begin
                            out_ld    = '{load: 1'b1, count: 5'd11, kind: KIND_TIME};
                            keep_sel  = KEEP_FROM_13;
                            fill_next = 5'(WindowBytes - 13);
                        end
                        MSG_DOP:
                        begin
                            out_ld = '{load: 1'b1, count: 5'd12, kind: KIND_DOP};
                        end
                        default:
                        begin
                            out_ld.load = 1'b0;
                        end
                    endcase
                end
            end
        end
    end

    // The window has no reset; every entry is written before it is read.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (!fills)
            begin
                win_reg[fill_reg] <= s_tdata;
            end
            else
            begin
                for (int i = 0; i < WindowBytes - 1; i++)
                begin
                    case (keep_sel)
                        KEEP_FROM_1:
                        begin
                            win_reg[i] <= win_full[i+1];
                        end
                        KEEP_FROM_13:
                        begin
                            if (i + 13 < WindowBytes)
                            begin
                                win_reg[i] <= win_full[i+13];
                            end
                        end
                        KEEP_FROM_14:
                        begin
                            if (i + 14 < WindowBytes)
                            begin
                                win_reg[i] <= win_full[i+14];
                            end
                        end
                        default:
                        begin
                            win_reg[i] <= win_reg[i];
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= 5'd0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    gbfe_out_buf u_out_buf (
        .clk         (clk),
        .rst_n       (rst_n),
        .ld          (out_ld),
        .frame_bytes (frame_bytes),
        .busy        (out_busy),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

`ifndef SYNTHESIS
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_ld.load |-> !out_busy)
        else $error("frame loaded while output buffer still draining");

    a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_ld.load |=> out_busy)
        else $error("output buffer not busy after a frame load");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= 5'(WindowBytes - 1))
        else $error("window fill count out of range");
`endif

endmodule

`default_nettype wire

// ===== rtl/gbfe_out_buf.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gbfe_out_buf
    import gbfe_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire frame_load_t ld,
    input  wire byte_t       frame_bytes [FrameBytes],
    output logic             busy,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // out_byte
    output logic [1:0]       m_tuser,   // frame_kind
    output logic             m_tlast    // last_byte
);

    byte_t       fb_reg [FrameBytes];
    logic [4:0]  left_reg;
    logic [3:0]  ptr_reg;
    frame_kind_t kind_reg;
    logic        valid_reg;
    logic [7:0]  data_reg;
    logic [1:0]  user_reg;
    logic        last_reg;
    logic        advance;

    assign advance = (left_reg != 5'd0) && (!valid_reg || m_tready);
    assign busy    = (left_reg != 5'd0);

    always_ff @(posedge clk)
    begin
        if (ld.load)
        begin
            for (int i = 0; i < FrameBytes; i++)
            begin
                fb_reg[i] <= frame_bytes[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg  <= 5'd0;
            ptr_reg   <= 4'd0;
            kind_reg  <= KIND_POS;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (ld.load)
            begin
                left_reg <= ld.count;
                ptr_reg  <= 4'd0;
                kind_reg <= ld.kind;
            end
            else if (advance)
            begin
                left_reg <= left_reg - 5'd1;
                ptr_reg  <= ptr_reg + 4'd1;
            end

            if (advance)
            begin
                valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= fb_reg[ptr_reg];
            user_reg <= kind_reg;
            last_reg <= (left_reg == 5'd1);
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

// ===== verif/gps_binary_frame_extractor_core_test.sv =====
`timescale 1ns / 1ps

module gps_binary_frame_extractor_core_test;
    import gbfe_pkg::*;

    localparam int TimeBytes   = 11;
    localparam int DopBytes    = 12;
    localparam int TimeTail    = 13;
    localparam int OtherTail   = 14;
    localparam int RandomBytes = 16;
    localparam int DrainCycles = 40;
    // Far above the slowest legal run: every word waiting out a long stall.
    localparam int CycleLimit  = 400000;

    localparam byte_t MSG_UNKNOWN = 8'h07;
    localparam byte_t BAD_CHECK   = 8'h55;

    typedef byte_t byte_q_t[$];

    typedef struct packed {
        byte_t       data;
        frame_kind_t kind;
        logic        last;
    } frame_word_t;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;

    byte_t       rx_window [WindowBytes];
    int          rx_fill = 0;
    frame_word_t words_due [$];
    int          frames_out = 0;
    int          bytes_sent = 0;
    int          errors = 0;
    int          cycles = 0;
    int          hold_cycles = 0;
    bit          steady = 1'b0;

    gps_binary_frame_extractor_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("gps_binary_frame_extractor_core_test failed");
            $finish;
        end
    end

    task automatic report(string msg);
        $display("%0t: %s", $time, msg);
        errors++;
    endtask

    // Window predictor.

    function automatic void keep_tail(int start);
        for (int i = start; i < WindowBytes; i++)
            rx_window[i - start] = rx_window[i];
        rx_fill = WindowBytes - start;
    endfunction

    function automatic void queue_frame(int count, frame_kind_t kind);
        frame_word_t w;
        for (int i = 0; i < count; i++)
        begin
            w.data = rx_window[i];
            w.kind = kind;
            w.last = (i == count - 1);
            words_due.push_back(w);
        end
        frames_out++;
    endfunction

    function automatic void window_accept(byte_t b);
        if (rx_fill < WindowBytes)
        begin
            rx_window[rx_fill] = b;
            rx_fill++;
        end
        if (rx_fill < WindowBytes)
            return;
        if (rx_window[0] != SYNC_BYTE || rx_window[1] != SYNC_BYTE)
            keep_tail(1);
        else if (rx_window[3] != CHECK_BYTE)
            keep_tail(OtherTail);
        else
        begin
            case (rx_window[2])
                MSG_POS:
                begin
                    queue_frame(FrameBytes, KIND_POS);
                    rx_fill = 0;
                end
                MSG_VEL:
                begin
                    queue_frame(FrameBytes, KIND_VEL);
                    rx_fill = 0;
                end
                MSG_TIME:
                begin
                    queue_frame(TimeBytes, KIND_TIME);
                    keep_tail(TimeTail);
                end
                MSG_DOP:
                begin
                    queue_frame(DopBytes, KIND_DOP);
                    keep_tail(OtherTail);
                end
                default: keep_tail(OtherTail);
            endcase
        end
    endfunction

    // Output checker.
    always @(posedge clk)
    begin
        frame_word_t w;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (words_due.size() == 0)
                report($sformatf("word %02h with no frame pending", m_tdata));
            else
            begin
                w = words_due.pop_front();
                if (m_tdata != w.data)
                    report($sformatf("out_byte %02h, expected %02h", m_tdata, w.data));
                if (m_tuser != w.kind)
                    report($sformatf("frame_kind %0d, expected %0d", m_tuser, w.kind));
                if (m_tlast != w.last)
                    report($sformatf("last_byte %0b, expected %0b", m_tlast, w.last));
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Receiver: random stalls, plus a long hold-off when a test asks for one.
    initial
    begin : receiver
        int stall;
        stall = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                m_tready <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!steady)
                    stall = pick_gap();
            end
        end
    end

    task automatic send_byte(byte_t b);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        bytes_sent++;
        window_accept(b);
    endtask

    task automatic sender_gap();
        int n;
        n = pick_gap();
        if (steady || n == 0)
            return;
        @(negedge clk);
        s_tvalid <= 1'b0;
        s_tdata  <= byte_t'($urandom);
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic send_all(byte_q_t q);
        foreach (q[i])
        begin
            send_byte(q[i]);
            sender_gap();
        end
    endtask

    task automatic wait_output_empty();
        while (words_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic byte_q_t frame_bytes(byte_t kind, byte_t check, int len);
        byte_q_t q;
        for (int i = 0; i < len; i++)
            q.push_back(byte_t'($urandom));
        q[0] = SYNC_BYTE;
        q[1] = SYNC_BYTE;
        q[2] = kind;
        q[3] = check;
        return q;
    endfunction

    function automatic byte_t pick_kind();
        case ($urandom_range(0, 9))
            0, 1:    return MSG_POS;
            2, 3:    return MSG_VEL;
            4, 5:    return MSG_TIME;
            6, 7:    return MSG_DOP;
            8:       return MSG_UNKNOWN;
            default: return byte_t'($urandom);
        endcase
    endfunction

    function automatic byte_t pick_check();
        return ($urandom_range(0, 9) == 0) ? byte_t'($urandom) : CHECK_BYTE;
    endfunction

    // Index of the first byte that a frame with this header leaves in the window.
    function automatic int tail_start(byte_t kind, byte_t check);
        if (check != CHECK_BYTE)
            return OtherTail;
        case (kind)
            MSG_POS, MSG_VEL: return 0;
            MSG_TIME:         return TimeTail;
            default:          return OtherTail;
        endcase
    endfunction

    // Completes the window into one frame. When a header already sits at the
    // start of the window only the rest is sent; often the kept tail is made
    // to open the next frame.
    task automatic stream_frame();
        byte_q_t q;
        bit      chained;
        int      base;
        int      k;
        chained = rx_fill >= 4 && rx_fill <= WindowBytes - 4 &&
                  rx_window[0] == SYNC_BYTE && rx_window[1] == SYNC_BYTE;
        base = chained ? rx_fill : 0;
        q = frame_bytes(pick_kind(), pick_check(), WindowBytes - base);
        if (chained)
        begin
            for (int i = 0; i < 4; i++)
                q[i] = byte_t'($urandom);
            k = tail_start(rx_window[2], rx_window[3]);
        end
        else
            k = tail_start(q[2], q[3]);
        if (k > 0 && k >= base && $urandom_range(0, 2) != 0)
        begin
            q[k - base]     = SYNC_BYTE;
            q[k - base + 1] = SYNC_BYTE;
            q[k - base + 2] = pick_kind();
            q[k - base + 3] = pick_check();
        end
        send_all(q);
    endtask

    task automatic test_frame_kinds();
        byte_q_t q;
        q = frame_bytes(MSG_POS, CHECK_BYTE, WindowBytes);
        q[4] = 8'h00;
        q[5] = 8'hFF;
        q[14] = 8'hFF;
        q[15] = 8'h00;
        send_all(q);
        wait_output_empty();
    endtask

    // A time frame whose tail opens a DOP frame, whose tail opens a header of
    // unknown kind, followed by a header that lacks the check byte.
    task automatic test_chained_frames();
        byte_q_t q;
        q = frame_bytes(MSG_TIME, CHECK_BYTE, TimeTail);
        q = {q, frame_bytes(MSG_DOP, CHECK_BYTE, OtherTail)};
        q = {q, frame_bytes(MSG_UNKNOWN, CHECK_BYTE, OtherTail)};
        q = {q, frame_bytes(MSG_POS, BAD_CHECK, WindowBytes)};
        send_all(q);
        wait_output_empty();
    endtask

    // Lone sync bytes ahead of a frame must be shifted out one at a time.
    task automatic test_resync();
        byte_q_t q;
        q = {8'hFF, SYNC_BYTE, 8'h00, 8'h00, SYNC_BYTE, 8'h12};
        q = {q, frame_bytes(MSG_DOP, CHECK_BYTE, WindowBytes)};
        send_all(q);
        wait_output_empty();
    endtask

    // The receiver holds off while frames keep coming, so the input stalls;
    // then the sender pauses until every frame byte is out.
    task automatic test_output_stall();
        steady = 1'b1;
        hold_cycles = 120;
        send_all(frame_bytes(MSG_VEL, CHECK_BYTE, WindowBytes));
        send_all(frame_bytes(MSG_POS, CHECK_BYTE, WindowBytes));
        steady = 1'b0;
        wait_output_empty();
    endtask

    task automatic test_random_stream();
        int sent_start;
        int frames_start;
        int n;
        sent_start = bytes_sent;
        frames_start = frames_out;
        while (bytes_sent - sent_start < RandomBytes || frames_out - frames_start < 1)
        begin
            steady = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 9) < 8)
                stream_frame();
            else
            begin
                n = $urandom_range(1, 6);
                repeat (n)
                begin
                    send_byte(($urandom_range(0, 3) == 0) ? SYNC_BYTE : byte_t'($urandom));
                    sender_gap();
                end
            end
        end
        steady = 1'b0;
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_frame_kinds();
        test_chained_frames();
        test_resync();
        test_output_stall();
        test_random_stream();

        @(negedge clk);
        s_tvalid <= 1'b0;
        wait_output_empty();
        repeat (DrainCycles) @(posedge clk);
        if (errors == 0)
            $display("gps_binary_frame_extractor_core_test passed");
        else
            $display("gps_binary_frame_extractor_core_test failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/gbfe_pkg.sv
rtl/gbfe_out_buf.sv
rtl/gps_binary_frame_extractor_core.sv
verif/gps_binary_frame_extractor_core_test.sv
